[hdl/nsf_pkg.sv]
// shared types, character codes and helpers for the nmea sentence framer
package nsf_pkg;

    localparam int unsigned NSF_MAX_FIELD_INDEX = 31;

    localparam int unsigned FIELD_NUM_W = 5;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    localparam logic [23:0] TYPE_RMC = "RMC";
    localparam logic [23:0] TYPE_GGA = "GGA";
    localparam logic [23:0] TYPE_GSA = "GSA";

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_RMC     = 2'd1;
    localparam logic [1:0] KIND_GGA     = 2'd2;
    localparam logic [1:0] KIND_GSA     = 2'd3;

    localparam logic [1:0] CHECK_MATCH    = 2'd0;
    localparam logic [1:0] CHECK_BAD_HEX  = 2'd1;
    localparam logic [1:0] CHECK_MISMATCH = 2'd2;

    typedef struct packed {
        logic [7:0]             payload_byte;
        logic [FIELD_NUM_W-1:0] field_number;
        logic                   is_field_char;
        logic                   closes_field;
        logic                   sentence_done;
        logic [1:0]             check_status;
        logic [1:0]             sentence_kind;
        logic [7:0]             computed_xor;
    } nsf_result_t;

    // bit 4 set marks a character that is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] n;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            n = 5'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            n = 5'(c - 8'h57);
        end
        else begin
            n = 5'h10;
        end
        return n;
    endfunction

endpackage

[hdl/nsf_core.sv]
// framing state machine, checksum accumulator and per-byte result logic
module nsf_core
    import nsf_pkg::*;
#(
    parameter int unsigned MAX_FIELD_INDEX = NSF_MAX_FIELD_INDEX
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  rx_byte,
    output nsf_result_t result
);

    localparam int unsigned CNT_W = $clog2(MAX_FIELD_INDEX + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELD_INDEX);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAYLOAD,
        PH_HEX_HI,
        PH_HEX_LO
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       xor_reg, xor_next;
    logic [4:0]       high_reg, high_next;
    logic [CNT_W-1:0] field_reg, field_next;
    logic [1:0]       tlen_reg, tlen_next;
    logic [23:0]      suffix_reg, suffix_next;
    logic [1:0]       kind_reg, kind_next;

    logic [1:0] type_kind;
    logic [4:0] nibble;

    assign nibble = hex_nibble(rx_byte);

    always_comb
    begin
        if (tlen_reg != 2'd3) begin
            type_kind = KIND_UNKNOWN;
        end
        else if (suffix_reg == TYPE_RMC) begin
            type_kind = KIND_RMC;
        end
        else if (suffix_reg == TYPE_GGA) begin
            type_kind = KIND_GGA;
        end
        else if (suffix_reg == TYPE_GSA) begin
            type_kind = KIND_GSA;
        end
        else begin
            type_kind = KIND_UNKNOWN;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        high_next   = high_reg;
        field_next  = field_reg;
        tlen_next   = tlen_reg;
        suffix_next = suffix_reg;
        kind_next   = kind_reg;

        result               = '0;
        result.payload_byte  = rx_byte;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == CHAR_DOLLAR) begin
                    phase_next  = PH_PAYLOAD;
                    xor_next    = '0;
                    high_next   = '0;
                    field_next  = '0;
                    tlen_next   = '0;
                    suffix_next = '0;
                    kind_next   = KIND_UNKNOWN;
                end
            end
            PH_PAYLOAD:
            begin
                if (rx_byte == CHAR_STAR || rx_byte == CHAR_COMMA) begin
                    result.closes_field = 1'b1;
                    if (field_reg == '0) begin
                        kind_next = type_kind;
                    end
                    if (rx_byte == CHAR_COMMA) begin
                        xor_next = xor_reg ^ rx_byte;
                        if (field_reg < CNT_MAX) begin
                            field_next = field_reg + CNT_W'(1);
                        end
                    end
                    else begin
                        phase_next = PH_HEX_HI;
                    end
                end
                else begin
                    result.is_field_char = 1'b1;
                    xor_next = xor_reg ^ rx_byte;
                    if (field_reg == '0) begin
                        suffix_next = {suffix_reg[15:0], rx_byte};
                        if (tlen_reg != 2'd3) begin
                            tlen_next = tlen_reg + 2'd1;
                        end
                    end
                end
            end
            PH_HEX_HI:
            begin
                high_next  = nibble;
                phase_next = PH_HEX_LO;
            end
            PH_HEX_LO:
            begin
                result.sentence_done = 1'b1;
                phase_next = PH_IDLE;
                if (high_reg[4] || nibble[4]) begin
                    result.check_status = CHECK_BAD_HEX;
                end
                else if ({high_reg[3:0], nibble[3:0]} != xor_reg) begin
                    result.check_status = CHECK_MISMATCH;
                end
                else begin
                    result.check_status = CHECK_MATCH;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (phase_reg != PH_IDLE) begin
            result.field_number  = FIELD_NUM_W'(field_reg);
            result.sentence_kind = kind_next;
            result.computed_xor  = xor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_IDLE;
            xor_reg    <= '0;
            high_reg   <= '0;
            field_reg  <= '0;
            tlen_reg   <= '0;
            suffix_reg <= '0;
            kind_reg   <= KIND_UNKNOWN;
        end
        else if (advance) begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            high_reg   <= high_next;
            field_reg  <= field_next;
            tlen_reg   <= tlen_next;
            suffix_reg <= suffix_next;
            kind_reg   <= kind_next;
        end
    end

endmodule

[hdl/nsf_out_stage.sv]
// result register with valid/ready handshake toward the consumer
module nsf_out_stage
    import nsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  nsf_result_t result_in,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output nsf_result_t result_out
);

    logic        valid_reg, valid_next;
    nsf_result_t data_reg;

    // stage frees up in the same cycle its contents transfer
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

[hdl/nmea_sentence_framer.sv]
// Streaming NMEA 0183 sentence framer: one result per received byte, valid in
// the cycle after its transfer, at a rate of one byte per clock while
// result_ready stays high. The framing state and running XOR update on each
// transfer, and the registered output stage takes the next byte only while it
// is empty or its result is taken. Bytes outside a sentence are echoed with all
// flags clear; field indexes stop at MAX_FIELD_INDEX and are reported in 5 bits.
module nmea_sentence_framer
    import nsf_pkg::*;
#(
    parameter int unsigned MAX_FIELD_INDEX = NSF_MAX_FIELD_INDEX
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rx_valid,
    output logic                   rx_ready,
    input  logic [7:0]             rx_byte,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [7:0]             payload_byte,
    output logic [FIELD_NUM_W-1:0] field_number,
    output logic                   is_field_char,
    output logic                   closes_field,
    output logic                   sentence_done,
    output logic [1:0]             check_status,
    output logic [1:0]             sentence_kind,
    output logic [7:0]             computed_xor
);

    logic        rx_xfer;
    nsf_result_t core_result;
    nsf_result_t out_result;

    assign rx_xfer = rx_valid && rx_ready;

    nsf_core #(
        .MAX_FIELD_INDEX(MAX_FIELD_INDEX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (rx_xfer),
        .rx_byte (rx_byte),
        .result  (core_result)
    );

    nsf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (rx_xfer),
        .result_in  (core_result),
        .can_load   (rx_ready),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .result_out (out_result)
    );

    assign payload_byte  = out_result.payload_byte;
    assign field_number  = out_result.field_number;
    assign is_field_char = out_result.is_field_char;
    assign closes_field  = out_result.closes_field;
    assign sentence_done = out_result.sentence_done;
    assign check_status  = out_result.check_status;
    assign sentence_kind = out_result.sentence_kind;
    assign computed_xor  = out_result.computed_xor;

`ifndef SYNTHESIS
    a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_xfer |=> result_valid)
        else $error("accepted byte produced no result");

    a_status_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !sentence_done |-> check_status == CHECK_MATCH)
        else $error("check status set outside sentence end");

    a_done_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sentence_done |-> !is_field_char && !closes_field)
        else $error("checksum digit flagged as payload");

    a_char_or_delim: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(is_field_char && closes_field))
        else $error("byte flagged as both field char and delimiter");
`endif

endmodule

[tb/testbench.sv]
// testbench for the nmea sentence framer: random byte streams checked against a local predictor
`timescale 1ns / 1ps

module testbench
    import nsf_pkg::*;
();

    typedef enum logic [1:0] {WAIT_START, IN_PAYLOAD, CSUM_HIGH, CSUM_LOW} framer_phase_t;
    typedef enum {SUM_UPPER, SUM_LOWER, SUM_WRONG, SUM_BAD_HIGH, SUM_BAD_LOW, SUM_BAD_BOTH,
                  SUM_TRUNCATED} csum_style_t;
    typedef enum {READY_ALWAYS, READY_COIN, READY_EVERY_THIRD} ready_style_t;

    localparam logic [4:0] NOT_A_DIGIT = 5'h10;
    localparam int TARGET_BYTES = 1050;
    localparam int HOLDOFF_AFTER = 400;
    localparam int HOLDOFF_CYCLES = 90;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rx_valid = 1'b0;
    logic rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [7:0] payload_byte;
    logic [FIELD_NUM_W-1:0] field_number;
    logic is_field_char;
    logic closes_field;
    logic sentence_done;
    logic [1:0] check_status;
    logic [1:0] sentence_kind;
    logic [7:0] computed_xor;

    // stimulus and scoreboard
    logic [7:0] pending_bytes[$];
    logic [7:0] sentence_body[$];
    nsf_result_t predicted_echoes[$];
    int sentence_bytes = 0;
    int bytes_offered = 0;
    int bytes_accepted = 0;
    int echoes_checked = 0;
    int mismatch_count = 0;

    // predictor state
    framer_phase_t frame_phase = WAIT_START;
    logic [7:0] run_xor = 8'h00;
    logic [4:0] hi_digit = 5'h00;
    int unsigned field_idx = 0;
    int unsigned type_len = 0;
    logic [23:0] type_tail = 24'h0;
    logic [1:0] kind_so_far = KIND_UNKNOWN;

    // sender and receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    int seg_left = 0;
    int beat = 0;
    ready_style_t ready_style = READY_ALWAYS;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    nmea_sentence_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_ready      (rx_ready),
        .rx_byte       (rx_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .payload_byte  (payload_byte),
        .field_number  (field_number),
        .is_field_char (is_field_char),
        .closes_field  (closes_field),
        .sentence_done (sentence_done),
        .check_status  (check_status),
        .sentence_kind (sentence_kind),
        .computed_xor  (computed_xor)
    );

    always #1 clk = ~clk;

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 5'(c - "0");
        end
        if (c >= "A" && c <= "F")
        begin
            return 5'(c - "A" + 8'd10);
        end
        if (c >= "a" && c <= "f")
        begin
            return 5'(c - "a" + 8'd10);
        end
        return NOT_A_DIGIT;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return "0" + {4'h0, n};
        end
        if (lower)
        begin
            return "a" + ({4'h0, n} - 8'd10);
        end
        return "A" + ({4'h0, n} - 8'd10);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (digit_value(c) != NOT_A_DIGIT);
        return c;
    endfunction

    // advances the predictor by one byte and returns the echo it should produce
    function automatic nsf_result_t frame_byte(input logic [7:0] b);
        nsf_result_t r;
        logic [4:0] lo;
        r = '0;
        r.payload_byte = b;
        case (frame_phase)
            WAIT_START:
            begin
                if (b == CHAR_DOLLAR)
                begin
                    frame_phase = IN_PAYLOAD;
                    run_xor = 8'h00;
                    hi_digit = 5'h00;
                    field_idx = 0;
                    type_len = 0;
                    type_tail = 24'h0;
                    kind_so_far = KIND_UNKNOWN;
                end
            end
            IN_PAYLOAD:
            begin
                r.field_number = field_idx[4:0];
                if (b == CHAR_STAR || b == CHAR_COMMA)
                begin
                    r.closes_field = 1'b1;
                    if (field_idx == 0)
                    begin
                        if (type_len < 3)
                            kind_so_far = KIND_UNKNOWN;
                        else if (type_tail == TYPE_RMC)
                            kind_so_far = KIND_RMC;
                        else if (type_tail == TYPE_GGA)
                            kind_so_far = KIND_GGA;
                        else if (type_tail == TYPE_GSA)
                            kind_so_far = KIND_GSA;
                        else
                            kind_so_far = KIND_UNKNOWN;
                    end
                    if (b == CHAR_COMMA)
                    begin
                        run_xor ^= b;
                        if (field_idx < NSF_MAX_FIELD_INDEX)
                            field_idx++;
                    end
                    else
                    begin
                        frame_phase = CSUM_HIGH;
                    end
                end
                else
                begin
                    r.is_field_char = 1'b1;
                    run_xor ^= b;
                    if (field_idx == 0)
                    begin
                        type_tail = {type_tail[15:0], b};
                        if (type_len < 3)
                            type_len++;
                    end
                end
            end
            CSUM_HIGH:
            begin
                hi_digit = digit_value(b);
                frame_phase = CSUM_LOW;
                r.field_number = field_idx[4:0];
            end
            default:
            begin
                lo = digit_value(b);
                r.sentence_done = 1'b1;
                r.field_number = field_idx[4:0];
                if (hi_digit[4] || lo[4])
                    r.check_status = CHECK_BAD_HEX;
                else if ({hi_digit[3:0], lo[3:0]} != run_xor)
                    r.check_status = CHECK_MISMATCH;
                else
                    r.check_status = CHECK_MATCH;
                frame_phase = WAIT_START;
            end
        endcase
        if (r.field_number != 0 || b != CHAR_DOLLAR || r.is_field_char || r.closes_field
            || r.sentence_done || frame_phase != IN_PAYLOAD || field_idx != 0
            || type_len != 0)
        begin
            // every byte inside a sentence carries the running kind and xor
            if (r.is_field_char || r.closes_field || r.sentence_done
                || frame_phase == CSUM_LOW || frame_phase == CSUM_HIGH
                || (frame_phase == IN_PAYLOAD && !(b == CHAR_DOLLAR && type_len == 0
                    && field_idx == 0 && run_xor == 8'h00 && !r.is_field_char)))
            begin
                r.sentence_kind = kind_so_far;
                r.computed_xor = run_xor;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("result %0d (byte 0x%02h): %s", echoes_checked, payload_byte, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            sentence_body.push_back(s[i]);
    endtask

    // field content: mostly printable, some arbitrary bytes, an occasional '$'
    task automatic add_field_bytes(input int n);
        logic [7:0] c;
        repeat (n)
        begin
            do
            begin
                if ($urandom_range(0, 15) == 0)
                    c = CHAR_DOLLAR;
                else if ($urandom_range(0, 3) == 0)
                    c = 8'($urandom_range(0, 255));
                else
                    c = 8'($urandom_range(8'h20, 8'h7E));
            end
            while (c == CHAR_COMMA || c == CHAR_STAR);
            sentence_body.push_back(c);
        end
    endtask

    task automatic push_sentence(input csum_style_t style);
        logic [7:0] sum;
        logic [7:0] hi;
        logic [7:0] lo;
        bit lower;
        sum = 8'h00;
        foreach (sentence_body[i])
            sum ^= sentence_body[i];
        pending_bytes.push_back(CHAR_DOLLAR);
        foreach (sentence_body[i])
            pending_bytes.push_back(sentence_body[i]);
        sentence_bytes += sentence_body.size() + 1;
        if (style != SUM_TRUNCATED)
        begin
            lower = (style == SUM_LOWER) ? 1'b1 : (style == SUM_UPPER) ? 1'b0
                                                : bit'($urandom_range(0, 1));
            if (style == SUM_WRONG)
                sum ^= 8'($urandom_range(1, 255));
            hi = hex_char(sum[7:4], lower);
            lo = hex_char(sum[3:0], lower);
            if (style == SUM_BAD_HIGH || style == SUM_BAD_BOTH)
                hi = non_hex_byte();
            if (style == SUM_BAD_LOW || style == SUM_BAD_BOTH)
                lo = non_hex_byte();
            pending_bytes.push_back(CHAR_STAR);
            pending_bytes.push_back(hi);
            pending_bytes.push_back(lo);
            sentence_bytes += 3;
        end
        sentence_body.delete();
    endtask

    // driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n || (rx_valid && bytes_offered != bytes_accepted))
        begin
            // hold the current offer until its transfer
        end
        else if (gap_left > 0)
        begin
            rx_valid <= 1'b0;
            gap_left--;
        end
        else if (pending_bytes.size() == 0)
        begin
            rx_valid <= 1'b0;
        end
        else
        begin
            rx_valid <= 1'b1;
            rx_byte <= pending_bytes.pop_front();
            bytes_offered++;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 12);
                gap_left = $urandom_range(1, 8);
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left--;
        end
        else if (!holdoff_done && bytes_offered >= HOLDOFF_AFTER)
        begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
        end
    end

    // receiver: segments of free flow, coin-flip stalls and a fixed one-in-three pattern
    always @(negedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_left = $urandom_range(8, 40);
            case ($urandom_range(0, 3))
                0: ready_style = READY_COIN;
                1: ready_style = READY_EVERY_THIRD;
                default: ready_style = READY_ALWAYS;
            endcase
        end
        seg_left--;
        beat++;
        if (holdoff_left > 0)
            result_ready <= 1'b0;
        else if (ready_style == READY_COIN)
            result_ready <= bit'($urandom_range(0, 1));
        else if (ready_style == READY_EVERY_THIRD)
            result_ready <= (beat % 3 == 0);
        else
            result_ready <= 1'b1;
    end

    // monitor: predict on input transfers, compare on result transfers
    always @(posedge clk)
    begin : monitor
        nsf_result_t want;
        if (rst_n && rx_valid && rx_ready)
        begin
            predicted_echoes.push_back(frame_byte(rx_byte));
            bytes_accepted++;
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_echoes.size() == 0)
            begin
                report_mismatch("result with no byte outstanding");
            end
            else
            begin
                want = predicted_echoes.pop_front();
                check_field("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
                check_field("field_number", 32'(field_number), 32'(want.field_number));
                check_field("is_field_char", 32'(is_field_char), 32'(want.is_field_char));
                check_field("closes_field", 32'(closes_field), 32'(want.closes_field));
                check_field("sentence_done", 32'(sentence_done), 32'(want.sentence_done));
                check_field("check_status", 32'(check_status), 32'(want.check_status));
                check_field("sentence_kind", 32'(sentence_kind), 32'(want.sentence_kind));
                check_field("computed_xor", 32'(computed_xor), 32'(want.computed_xor));
            end
            echoes_checked++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin : stimulus
        int nfields;
        csum_style_t style;
        bit first_random;

        // idle bytes at both extremes
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        // empty sentence with a good checksum
        push_sentence(SUM_UPPER);
        // dollar inside the payload, bad first checksum digit
        add_text("RMC,$");
        push_sentence(SUM_BAD_HIGH);
        add_text("GGA");
        push_sentence(SUM_BAD_LOW);
        add_text("GSA");
        push_sentence(SUM_WRONG);

        first_random = 1'b1;
        while (sentence_bytes < TARGET_BYTES)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 7))
                0: add_text("GPRMC");
                1: add_text("GNGGA");
                2: add_text("GPGSA");
                3: add_text("GSA");
                4: add_text("GP");
                5: ;
                default: add_field_bytes($urandom_range(1, 6));
            endcase
            // the first random sentence always takes the field index up to its limit
            nfields = (first_random || $urandom_range(0, 24) == 0) ? $urandom_range(31, 38)
                                                                    : $urandom_range(0, 8);
            first_random = 1'b0;
            repeat (nfields)
            begin
                sentence_body.push_back(CHAR_COMMA);
                add_field_bytes($urandom_range(0, 6));
            end
            case ($urandom_range(0, 11))
                0: style = SUM_WRONG;
                1: style = SUM_BAD_HIGH;
                2: style = SUM_BAD_LOW;
                3: style = SUM_BAD_BOTH;
                4: style = SUM_TRUNCATED;
                5, 6, 7: style = SUM_LOWER;
                default: style = SUM_UPPER;
            endcase
            push_sentence(style);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || bytes_offered != bytes_accepted
               || predicted_echoes.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[nmea_sentence_framer.f]
hdl/nsf_pkg.sv
hdl/nsf_core.sv
hdl/nsf_out_stage.sv
hdl/nmea_sentence_framer.sv
tb/testbench.sv
